### design/vmc_pkg.sv
`default_nettype none

package vmc_pkg;

  localparam int unsigned ItemCountDefault = 4;
  localparam int unsigned StockBitsDefault = 8;

  localparam int unsigned PriceCount = 4;
  localparam int unsigned MoneyW     = 16;
  localparam int unsigned PinW       = 14;
  localparam int unsigned QtyW       = 8;
  localparam int unsigned CfgIdxW    = 3;
  localparam int unsigned CfgDataW   = 16;

  localparam logic [CfgIdxW-1:0] CfgPrice0  = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgPrice1  = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgPrice2  = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgPrice3  = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgOpCode  = 3'd4;

  localparam logic [MoneyW-1:0] PriceRst0  = 16'd2500;
  localparam logic [MoneyW-1:0] PriceRst1  = 16'd1500;
  localparam logic [PinW-1:0]   OpCodeRst  = 14'd1234;
  localparam int unsigned       StockRst0  = 5;
  localparam int unsigned       StockRst1  = 3;

  typedef enum logic [2:0] {
    OP_SELECT    = 3'd0,
    OP_INSERT    = 3'd1,
    OP_DISPENSE  = 3'd2,
    OP_CANCEL    = 3'd3,
    OP_MAINT_IN  = 3'd4,
    OP_MAINT_OUT = 3'd5,
    OP_RESTOCK   = 3'd6,
    OP_RESET     = 3'd7
  } op_e;

  typedef enum logic [1:0] {
    MODE_IDLE       = 2'd0,
    MODE_PENDING    = 2'd1,
    MODE_DISPENSING = 2'd2,
    MODE_MAINT      = 2'd3
  } mode_e;

  typedef enum logic [3:0] {
    STS_SELECTED    = 4'd0,
    STS_UNAVAILABLE = 4'd1,
    STS_NEED_MORE   = 4'd2,
    STS_PAID        = 4'd3,
    STS_REFUNDED    = 4'd4,
    STS_DISPENSED   = 4'd5,
    STS_WRONG_STATE = 4'd6,
    STS_MAINT_IN    = 4'd7,
    STS_MAINT_OUT   = 4'd8,
    STS_REJECTED    = 4'd9,
    STS_RESTOCKED   = 4'd10,
    STS_RESET       = 4'd11
  } status_e;

  typedef struct packed {
    op_e               operation;
    logic [2:0]        item_index;
    logic [MoneyW-1:0] money_in;
    logic [PinW-1:0]   pin_entry;
    logic [QtyW-1:0]   restock_count;
  } in_item_t;

  typedef struct packed {
    status_e           status;
    mode_e             mode_out;
    logic [MoneyW-1:0] amount_out;
    logic [1:0]        item_out;
  } out_item_t;

  typedef struct packed {
    logic [PriceCount-1:0][MoneyW-1:0] price;
    logic [PinW-1:0]                   op_code;
  } cfg_t;

endpackage

`default_nettype wire

### design/vmc_if.sv
`default_nettype none

interface vmc_item_if;
  import vmc_pkg::*;
  logic     valid;
  logic     ready;
  in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface vmc_result_if;
  import vmc_pkg::*;
  logic      valid;
  logic      ready;
  out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface vmc_cfg_if;
  import vmc_pkg::*;
  logic                valid;
  logic                ready;
  logic [CfgIdxW-1:0]  index;
  logic [CfgDataW-1:0] wdata;
  modport source (output valid, output index, output wdata, input ready);
  modport sink (input valid, input index, input wdata, output ready);
endinterface

`default_nettype wire

### design/vmc_cfg.sv
`default_nettype none

module vmc_cfg
  import vmc_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  vmc_cfg_if.sink  cfg_i,
  output cfg_t     cfg_o
);

  cfg_t cfg_q;

  assign cfg_i.ready = 1'b1;
  assign cfg_o       = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.price[0] <= PriceRst0;
      cfg_q.price[1] <= PriceRst1;
      cfg_q.price[2] <= '0;
      cfg_q.price[3] <= '0;
      cfg_q.op_code  <= OpCodeRst;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        CfgPrice0: cfg_q.price[0] <= cfg_i.wdata;
        CfgPrice1: cfg_q.price[1] <= cfg_i.wdata;
        CfgPrice2: cfg_q.price[2] <= cfg_i.wdata;
        CfgPrice3: cfg_q.price[3] <= cfg_i.wdata;
        CfgOpCode: cfg_q.op_code  <= cfg_i.wdata[PinW-1:0];
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

### design/vmc_engine.sv
`default_nettype none

module vmc_engine
  import vmc_pkg::*;
#(
  parameter int unsigned ITEM_COUNT = ItemCountDefault,
  parameter int unsigned STOCK_BITS = StockBitsDefault
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  input  wire cfg_t   cfg_i,
  vmc_item_if.sink    in_i,
  vmc_result_if.source out_o
);

  localparam int unsigned ItemW = (ITEM_COUNT > 2) ? 2 : 1;
  localparam int unsigned SumW  = ((STOCK_BITS > QtyW) ? STOCK_BITS : QtyW) + 1;
  localparam logic [STOCK_BITS-1:0] StockMax = '1;

  // input stage
  logic     s1_valid_q;
  in_item_t s1_q;
  // output stage
  logic      out_valid_q;
  out_item_t out_q;
  // machine state
  mode_e                 mode_q, mode_d;
  logic [MoneyW-1:0]     credit_q, credit_d;
  logic [1:0]            chosen_q, chosen_d;
  logic [STOCK_BITS-1:0] stock_q [ITEM_COUNT];
  logic [STOCK_BITS-1:0] stock_d [ITEM_COUNT];
  logic [STOCK_BITS-1:0] stock_rst [ITEM_COUNT];

  logic      out_free, fire;
  out_item_t res;

  logic [ItemW-1:0]  ci, ii;
  logic [MoneyW-1:0] price, credit_new;
  logic [MoneyW:0]   credit_sum;
  logic [SumW-1:0]   stock_sum;
  logic              item_ok;

  assign out_free   = !out_valid_q || out_o.ready;
  assign fire       = s1_valid_q && out_free;
  assign in_i.ready = !s1_valid_q || fire;
  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_q;

  always_comb begin
    for (int i = 0; i < ITEM_COUNT; i++) begin
      stock_rst[i] = (i == 0) ? STOCK_BITS'(StockRst0) :
                     (i == 1) ? STOCK_BITS'(StockRst1) : '0;
    end
  end

  assign ci      = chosen_q[ItemW-1:0];
  assign ii      = s1_q.item_index[ItemW-1:0];
  assign price   = cfg_i.price[chosen_q];
  assign item_ok = s1_q.item_index < 3'(ITEM_COUNT);

  assign credit_sum = {1'b0, credit_q} + {1'b0, s1_q.money_in};
  assign credit_new = credit_sum[MoneyW] ? '1 : credit_sum[MoneyW-1:0];
  assign stock_sum  = SumW'(stock_q[ii]) + SumW'(s1_q.restock_count);

  always_comb begin
    mode_d   = mode_q;
    credit_d = credit_q;
    chosen_d = chosen_q;
    stock_d  = stock_q;
    res.status     = STS_WRONG_STATE;
    res.amount_out = '0;
    res.item_out   = chosen_q;
    case (s1_q.operation)
      OP_SELECT: begin
        if (mode_q == MODE_IDLE) begin
          if (item_ok && (stock_q[ii] != '0)) begin
            chosen_d       = s1_q.item_index[1:0];
            mode_d         = MODE_PENDING;
            res.status     = STS_SELECTED;
            res.amount_out = cfg_i.price[s1_q.item_index[1:0]];
            res.item_out   = s1_q.item_index[1:0];
          end else begin
            res.status = STS_UNAVAILABLE;
          end
        end
      end
      OP_INSERT: begin
        if (mode_q == MODE_PENDING) begin
          credit_d = credit_new;
          if (credit_new >= price) begin
            mode_d     = MODE_DISPENSING;
            res.status = STS_PAID;
          end else begin
            res.status     = STS_NEED_MORE;
            res.amount_out = price - credit_new;
          end
        end
      end
      OP_DISPENSE: begin
        if (mode_q == MODE_DISPENSING) begin
          if (stock_q[ci] != '0) begin
            stock_d[ci] = stock_q[ci] - 1'b1;
          end
          res.amount_out = (credit_q > price) ? credit_q - price : '0;
          res.status     = STS_DISPENSED;
          credit_d = '0;
          chosen_d = '0;
          mode_d   = MODE_IDLE;
        end
      end
      OP_CANCEL: begin
        if (mode_q == MODE_PENDING) begin
          res.amount_out = credit_q;
          res.status     = STS_REFUNDED;
          credit_d = '0;
          chosen_d = '0;
          mode_d   = MODE_IDLE;
        end
      end
      OP_MAINT_IN: begin
        if ((s1_q.pin_entry == cfg_i.op_code) && (mode_q == MODE_IDLE)) begin
          mode_d     = MODE_MAINT;
          res.status = STS_MAINT_IN;
        end else begin
          res.status = STS_REJECTED;
        end
      end
      OP_MAINT_OUT: begin
        if ((s1_q.pin_entry == cfg_i.op_code) && (mode_q == MODE_MAINT)) begin
          mode_d     = MODE_IDLE;
          res.status = STS_MAINT_OUT;
        end else begin
          res.status = STS_REJECTED;
        end
      end
      OP_RESTOCK: begin
        if (mode_q != MODE_MAINT) begin
          res.status = STS_REJECTED;
        end else if (!item_ok) begin
          res.status = STS_UNAVAILABLE;
        end else begin
          // saturate rather than wrap
          stock_d[ii]  = (stock_sum > SumW'(StockMax)) ? StockMax
                                                       : stock_sum[STOCK_BITS-1:0];
          res.status   = STS_RESTOCKED;
          res.item_out = s1_q.item_index[1:0];
        end
      end
      OP_RESET: begin
        credit_d     = '0;
        chosen_d     = '0;
        mode_d       = MODE_IDLE;
        stock_d      = stock_rst;
        res.status   = STS_RESET;
        res.item_out = '0;
      end
      default: ;
    endcase
    res.mode_out = mode_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_i.valid && in_i.ready) begin
      s1_valid_q <= 1'b1;
    end else if (fire) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      s1_q <= in_i.data;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fire) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_q <= res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= MODE_IDLE;
      credit_q <= '0;
      chosen_q <= '0;
      stock_q  <= stock_rst;
    end else if (fire) begin
      mode_q   <= mode_d;
      credit_q <= credit_d;
      chosen_q <= chosen_d;
      stock_q  <= stock_d;
    end
  end

endmodule

`default_nettype wire

### design/vending_machine_controller_top.sv
`default_nettype none

// channel   dir  payload                                            accepted when
// in_i      in   operation, item_index, money_in, pin_entry,        valid && ready
//                restock_count
// out_o     out  status, mode_out, amount_out, item_out             valid && ready
// cfg_i     in   index (0..3 prices, 4 operator code), wdata        valid && ready
//
// one item per cycle sustained while out_o does not stall; each item passes the input
// register, then the result register, before its result can be taken
// the event logic sits between the two registers; ready depends on out_o.ready
// only when both stages hold an item
// rst_ni clears mode, credit, selection and stock to power-on values and
// restores the register defaults; the config port is always ready

module vending_machine_controller_top
  import vmc_pkg::*;
#(
  parameter int unsigned ITEM_COUNT = ItemCountDefault,
  parameter int unsigned STOCK_BITS = StockBitsDefault
) (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  vmc_item_if.sink     in_i,
  vmc_result_if.source out_o,
  vmc_cfg_if.sink      cfg_i
);

  cfg_t cfg;

  vmc_cfg u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .cfg_o  (cfg)
  );

  vmc_engine #(
    .ITEM_COUNT (ITEM_COUNT),
    .STOCK_BITS (STOCK_BITS)
  ) u_engine (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg),
    .in_i   (in_i),
    .out_o  (out_o)
  );

  a_dispense_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && (out_o.data.status == STS_DISPENSED) |-> out_o.data.mode_out == MODE_IDLE)
    else $error("dispense did not return to idle");

  a_paid_dispensing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && (out_o.data.status == STS_PAID)
      |-> (out_o.data.mode_out == MODE_DISPENSING) && (out_o.data.amount_out == '0))
    else $error("paid result with wrong mode or amount");

  a_reset_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && (out_o.data.status == STS_RESET)
      |-> (out_o.data.amount_out == '0) && (out_o.data.item_out == '0)
          && (out_o.data.mode_out == MODE_IDLE))
    else $error("reset operation left state behind");

  a_restock_maint: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && (out_o.data.status == STS_RESTOCKED) |-> out_o.data.mode_out == MODE_MAINT)
    else $error("restock accepted outside maintenance");

endmodule

`default_nettype wire
